/* rtl/gbns_pkg.sv */
// Package for the Go-Back-N send window: field widths, codes, payload structs.
// Used by the channel interfaces, the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package gbns_pkg;

   localparam int SEQ_W = 16;
   localparam int LEN_W = 11;
   localparam int OP_W = 2;
   localparam int KIND_W = 3;

   localparam int WINDOW_DEF = 16;
   localparam int SEGMENT_BYTES_DEF = 1024;

   // Largest usable sequence number plus one; also the rejected ack value.
   localparam logic [SEQ_W-1:0] SEQ_LIMIT = 16'hFFFF;
   localparam int LEN_MAX = 2047;

   typedef enum logic [OP_W-1:0] {
      OP_OFFER  = 2'd0,
      OP_ACK    = 2'd1,
      OP_EXPIRE = 2'd2
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_SEND     = 3'd0,
      KIND_RETX     = 3'd1,
      KIND_REFUSED  = 3'd2,
      KIND_ADVANCED = 3'd3,
      KIND_NONE     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PLAN,
      ST_FETCH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [LEN_W-1:0] seg_len;
      logic [SEQ_W-1:0] ack_num;
      logic             ack_flag_data;
      logic             checksum_ok;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SEQ_W-1:0]  seq;
      logic [LEN_W-1:0]  length;
      logic              last;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* rtl/gbns_if.sv */
// Valid/ready channel interfaces for the request and response sides.
// Depends on gbns_pkg for the payload structs.
`timescale 1ns / 1ps
`default_nettype none

interface gbns_req_if;
   logic                      valid;
   logic                      ready;
   gbns_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface gbns_rsp_if;
   logic                      valid;
   logic                      ready;
   gbns_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/go_back_n_send_window.sv */
// Sender window of a batched Go-Back-N scheme with a ring of segment lengths.
// Depends on gbns_pkg and the channel interfaces in gbns_if.sv.
//
// Usage: requests arrive on req_chan (offer segment, acknowledgement, wait
// expiry); results leave on rsp_chan through a single output register. A beat
// is taken when valid and ready are both high on a rising clock edge.
// An offer or an acknowledgement leaves the block in ST_IDLE; the send or refuse
// result is valid in the cycle after acceptance. An acknowledgement gives no
// result. A wait expiry that advances the window answers in the cycle after acceptance.
// A wait expiry that goes back passes through planning in ST_PLAN and a length
// ring read in ST_FETCH before ST_EMIT registers its first retransmit beat;
// after that the length ring delivers one retransmit per cycle as long as
// rsp_chan.ready stays high. The single-port read of the length ring sets
// that rate. One that finds nothing outstanding answers from ST_PLAN once
// the output register is free.
// Reset is synchronous and clears the window registers and the output valid;
// the length ring is not cleared, there is no clearing pass. When the
// receiver holds rsp_chan.ready low, the pending beat is held and req_chan is
// not ready until that beat has been taken or is being taken.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_send_window #(
   parameter int WINDOW = gbns_pkg::WINDOW_DEF,
   parameter int SEGMENT_BYTES = gbns_pkg::SEGMENT_BYTES_DEF
) (
   input  wire            clock,
   input  wire            reset,
   gbns_req_if.sink       req_chan,
   gbns_rsp_if.source     rsp_chan
);

   localparam int SEQ_W = gbns_pkg::SEQ_W;
   localparam int LEN_W = gbns_pkg::LEN_W;
   localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW = $clog2(WINDOW + 1);
   localparam int SW = CW + 1;
   localparam int LEN_CAP_I = (SEGMENT_BYTES > gbns_pkg::LEN_MAX) ?
                              gbns_pkg::LEN_MAX : SEGMENT_BYTES;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_I);
   localparam logic [IW-1:0] IDX_LAST = IW'(WINDOW - 1);

   gbns_pkg::state_type state_ff, state_in;
   logic [SEQ_W-1:0] base_ff, base_in;
   logic [SEQ_W-1:0] next_ff, next_in;
   logic [SEQ_W-1:0] high_ff, high_in;
   logic             any_ack_ff, any_ack_in;
   logic             all_acked_ff, all_acked_in;
   logic [SEQ_W-1:0] exp_ack_ff, exp_ack_in;
   logic [IW-1:0]    next_idx_ff, next_idx_in;
   logic [SEQ_W-1:0] walk_seq_ff, walk_seq_in;
   logic [IW-1:0]    walk_idx_ff, walk_idx_in;
   logic [CW-1:0]    remain_ff, remain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   gbns_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [LEN_W-1:0] ring_mem [WINDOW];
   logic [LEN_W-1:0] ram_q_ff;
   logic             wr_en;
   logic [LEN_W-1:0] wr_len;
   logic [IW-1:0]    rd_addr;

   logic             out_free;
   logic             req_take;
   logic [SEQ_W:0]   limit;
   logic [SEQ_W:0]   limit_m1;
   logic [SEQ_W-1:0] exp_sat;
   logic [SEQ_W-1:0] adv_sat;
   logic             fits;
   logic             ack_good;
   logic [SEQ_W-1:0] diff;
   logic [CW-1:0]    cnt;
   logic [SW-1:0]    nidx_ext;
   logic [SW-1:0]    start_idx;
   logic [IW-1:0]    idx_nxt;

   gbns_pkg::req_payload_type req;

   assign req = req_chan.payload;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == gbns_pkg::ST_IDLE) && out_free;
   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Window arithmetic, saturated to the top of the sequence space.
   assign limit = {1'b0, base_ff} + (SEQ_W + 1)'(WINDOW);
   assign limit_m1 = limit - 1'b1;
   assign exp_sat = limit_m1[SEQ_W] ? gbns_pkg::SEQ_LIMIT : limit_m1[SEQ_W-1:0];
   assign adv_sat = limit[SEQ_W] ? gbns_pkg::SEQ_LIMIT : limit[SEQ_W-1:0];
   assign fits = (next_ff != gbns_pkg::SEQ_LIMIT) && ({1'b0, next_ff} < limit);
   assign wr_len = (req.seg_len > LEN_CAP) ? LEN_CAP : req.seg_len;
   assign ack_good = req.checksum_ok && req.ack_flag_data &&
                     (req.ack_num != gbns_pkg::SEQ_LIMIT);

   // Only the newest WINDOW outstanding segments are still in the ring.
   assign diff = next_ff - base_ff;
   assign cnt = (diff > SEQ_W'(WINDOW)) ? CW'(WINDOW) : diff[CW-1:0];
   assign nidx_ext = SW'(next_idx_ff);
   assign start_idx = (nidx_ext >= SW'(cnt)) ? (nidx_ext - SW'(cnt)) :
                      (nidx_ext + SW'(WINDOW) - SW'(cnt));
   assign idx_nxt = (walk_idx_ff == IDX_LAST) ? '0 : walk_idx_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      next_in = next_ff;
      high_in = high_ff;
      any_ack_in = any_ack_ff;
      all_acked_in = all_acked_ff;
      exp_ack_in = exp_ack_ff;
      next_idx_in = next_idx_ff;
      walk_seq_in = walk_seq_ff;
      walk_idx_in = walk_idx_ff;
      remain_in = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in = rsp_data_ff;
      wr_en = 1'b0;
      rd_addr = walk_idx_ff;

      case (state_ff)
         gbns_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req.op)
                  gbns_pkg::OP_OFFER: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in.seq = next_ff;
                     rsp_data_in.last = 1'b1;
                     if (fits) begin
                        wr_en = 1'b1;
                        all_acked_in = 1'b0;
                        exp_ack_in = exp_sat;
                        next_in = next_ff + 1'b1;
                        next_idx_in = (next_idx_ff == IDX_LAST) ? '0 : next_idx_ff + 1'b1;
                        rsp_data_in.kind = gbns_pkg::KIND_SEND;
                        rsp_data_in.length = wr_len;
                     end else begin
                        rsp_data_in.kind = gbns_pkg::KIND_REFUSED;
                        rsp_data_in.length = '0;
                     end
                  end
                  gbns_pkg::OP_ACK: begin
                     if (ack_good) begin
                        if (!any_ack_ff || (req.ack_num > high_ff)) begin
                           high_in = req.ack_num;
                           any_ack_in = 1'b1;
                        end
                        if (req.ack_num == exp_ack_ff) begin
                           all_acked_in = 1'b1;
                        end
                     end
                  end
                  gbns_pkg::OP_EXPIRE: begin
                     if (all_acked_ff) begin
                        base_in = adv_sat;
                        rsp_valid_in = 1'b1;
                        rsp_data_in.kind = gbns_pkg::KIND_ADVANCED;
                        rsp_data_in.seq = adv_sat;
                        rsp_data_in.length = '0;
                        rsp_data_in.last = 1'b1;
                     end else begin
                        base_in = any_ack_ff ? (high_ff + 1'b1) : '0;
                        state_in = gbns_pkg::ST_PLAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         gbns_pkg::ST_PLAN: begin
            if (base_ff >= next_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in.kind = gbns_pkg::KIND_NONE;
                  rsp_data_in.seq = base_ff;
                  rsp_data_in.length = '0;
                  rsp_data_in.last = 1'b1;
                  state_in = gbns_pkg::ST_IDLE;
               end
            end else begin
               walk_seq_in = next_ff - SEQ_W'(cnt);
               walk_idx_in = start_idx[IW-1:0];
               remain_in = cnt;
               state_in = gbns_pkg::ST_FETCH;
            end
         end
         gbns_pkg::ST_FETCH: begin
            state_in = gbns_pkg::ST_EMIT;
         end
         gbns_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.kind = gbns_pkg::KIND_RETX;
               rsp_data_in.seq = walk_seq_ff;
               rsp_data_in.length = ram_q_ff;
               rsp_data_in.last = (remain_ff == CW'(1));
               if (remain_ff == CW'(1)) begin
                  state_in = gbns_pkg::ST_IDLE;
               end else begin
                  // Read ahead so the next length is ready in the next cycle.
                  walk_seq_in = walk_seq_ff + 1'b1;
                  walk_idx_in = idx_nxt;
                  remain_in = remain_ff - 1'b1;
                  rd_addr = idx_nxt;
               end
            end
         end
         default: begin
            state_in = gbns_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbns_pkg::ST_IDLE;
         base_ff <= '0;
         next_ff <= '0;
         high_ff <= '0;
         any_ack_ff <= 1'b0;
         all_acked_ff <= 1'b0;
         exp_ack_ff <= '0;
         next_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         next_ff <= next_in;
         high_ff <= high_in;
         any_ack_ff <= any_ack_in;
         all_acked_ff <= all_acked_in;
         exp_ack_ff <= exp_ack_in;
         next_idx_ff <= next_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_seq_ff <= walk_seq_in;
      walk_idx_ff <= walk_idx_in;
      remain_ff <= remain_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Length ring: one write port for sends, one registered read port for the walk.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[next_idx_ff] <= wr_len;
      end
      ram_q_ff <= ring_mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/gbns_checker.sv */
// Port-level checks for go_back_n_send_window, attached with a bind.
// Depends on gbns_pkg for the response struct and kind codes.
`timescale 1ns / 1ps
`default_nettype none

module gbns_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_ready,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input wire gbns_pkg::rsp_payload_type rsp_payload
);

   // A stalled response beat keeps its valid and its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response beat changed");

   // The response register is empty right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // A new request is not taken while the response slot is blocked.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request ready while response stalled");

   // Only retransmits come in bursts; everything else is the final beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind != gbns_pkg::KIND_RETX) |-> rsp_payload.last)
      else $error("non-retransmit beat without last");

   // Inside a retransmit burst no request is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == gbns_pkg::KIND_RETX) && !rsp_payload.last
      |-> !req_ready)
      else $error("request ready inside retransmit burst");

endmodule

bind go_back_n_send_window gbns_checker u_gbns_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire

/* dv/go_back_n_send_window_test.sv */
// Self-checking testbench for the Go-Back-N send window: directed and random
// offers, acks and wait expiries, checked beat by beat against an in-bench model.
// Depends on gbns_pkg (rtl/gbns_pkg.sv) and the channel interfaces in rtl/gbns_if.sv.
`timescale 1ns / 1ps

module go_back_n_send_window_test;

   localparam int SEQ_W = gbns_pkg::SEQ_W;
   localparam int LEN_W = gbns_pkg::LEN_W;
   localparam int REQ_W = $bits(gbns_pkg::req_payload_type);
   localparam int WINDOW = gbns_pkg::WINDOW_DEF;
   localparam int SEGMENT_BYTES = gbns_pkg::SEGMENT_BYTES_DEF;
   localparam int LEN_MAX = gbns_pkg::LEN_MAX;
   localparam logic [SEQ_W-1:0] SEQ_LIMIT = gbns_pkg::SEQ_LIMIT;
   localparam logic [gbns_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   // Base used to walk the window up against the top of the sequence space.
   localparam logic [SEQ_W-1:0] HIGH_BASE = SEQ_LIMIT - 16'(2 * WINDOW - 1);

   logic clock = 1'b0;
   logic reset;

   gbns_req_if req_chan();
   gbns_rsp_if rsp_chan();

   go_back_n_send_window dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   // Model of the sender window.
   logic [SEQ_W-1:0] win_base = '0;
   logic [SEQ_W-1:0] next_seq = '0;
   logic [SEQ_W-1:0] top_ack = '0;
   logic             ack_seen = 1'b0;
   logic             all_acked = 1'b0;
   logic [SEQ_W-1:0] full_ack_num = '0;
   logic [LEN_W-1:0] seg_lens [WINDOW];

   gbns_pkg::rsp_payload_type window_notices_due [$];
   int unsigned mismatches = 0;
   bit quiet = 1'b0;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   function automatic logic [SEQ_W-1:0] clamp_seq(input int unsigned v);
      return (v > SEQ_LIMIT) ? SEQ_LIMIT : v[SEQ_W-1:0];
   endfunction

   function automatic void push_notice(input gbns_pkg::kind_type kind,
                                       input logic [SEQ_W-1:0] seq,
                                       input logic [LEN_W-1:0] len, input logic last);
      gbns_pkg::rsp_payload_type n;
      n.kind = kind;
      n.seq = seq;
      n.length = len;
      n.last = last;
      window_notices_due.push_back(n);
   endfunction

   function automatic void apply_to_window(input gbns_pkg::req_payload_type item);
      logic [LEN_W-1:0] len;
      int unsigned first;
      case (item.op)
         gbns_pkg::OP_OFFER: begin
            if (next_seq != SEQ_LIMIT && {16'd0, next_seq} < win_base + WINDOW) begin
               if (item.seg_len > SEGMENT_BYTES)
                  len = LEN_W'(SEGMENT_BYTES);
               else
                  len = item.seg_len;
               all_acked = 1'b0;
               full_ack_num = clamp_seq(win_base + WINDOW - 1);
               seg_lens[next_seq % WINDOW] = len;
               push_notice(gbns_pkg::KIND_SEND, next_seq, len, 1'b1);
               next_seq = next_seq + 16'd1;
            end else begin
               push_notice(gbns_pkg::KIND_REFUSED, next_seq, '0, 1'b1);
            end
         end
         gbns_pkg::OP_ACK: begin
            if (item.checksum_ok && item.ack_flag_data && item.ack_num != SEQ_LIMIT) begin
               if (!ack_seen || item.ack_num > top_ack) begin
                  top_ack = item.ack_num;
                  ack_seen = 1'b1;
               end
               if (item.ack_num == full_ack_num)
                  all_acked = 1'b1;
            end
         end
         gbns_pkg::OP_EXPIRE: begin
            if (all_acked) begin
               win_base = clamp_seq(win_base + WINDOW);
               push_notice(gbns_pkg::KIND_ADVANCED, win_base, '0, 1'b1);
            end else begin
               win_base = ack_seen ? top_ack + 16'd1 : '0;
               if (win_base >= next_seq) begin
                  push_notice(gbns_pkg::KIND_NONE, win_base, '0, 1'b1);
               end else begin
                  // Older ring entries are overwritten, so only the newest window is resent.
                  first = 32'(win_base);
                  if (next_seq - first > WINDOW)
                     first = next_seq - WINDOW;
                  for (int unsigned s = first; s < next_seq; s++)
                     push_notice(gbns_pkg::KIND_RETX, s[SEQ_W-1:0], seg_lens[s % WINDOW],
                                 s + 1 == next_seq);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input gbns_pkg::req_payload_type item);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      apply_to_window(item);
   endtask

   // Fields that the operation does not use carry random bits.
   task automatic send_offer(input logic [LEN_W-1:0] len);
      gbns_pkg::req_payload_type item;
      item = REQ_W'($urandom);
      item.op = gbns_pkg::OP_OFFER;
      item.seg_len = len;
      send_item(item);
   endtask

   task automatic send_ack(input logic [SEQ_W-1:0] num, input logic flag_data,
                           input logic csum_ok);
      gbns_pkg::req_payload_type item;
      item = REQ_W'($urandom);
      item.op = gbns_pkg::OP_ACK;
      item.ack_num = num;
      item.ack_flag_data = flag_data;
      item.checksum_ok = csum_ok;
      send_item(item);
   endtask

   task automatic send_expiry();
      gbns_pkg::req_payload_type item;
      item = REQ_W'($urandom);
      item.op = gbns_pkg::OP_EXPIRE;
      send_item(item);
   endtask

   // A beat the block must ignore: an unknown op or a rejected ack.
   task automatic send_noise();
      gbns_pkg::req_payload_type item;
      item = REQ_W'($urandom);
      case ($urandom_range(0, 3))
         0: item.op = OP_UNUSED;
         1: begin
            item.op = gbns_pkg::OP_ACK;
            item.checksum_ok = 1'b0;
         end
         2: begin
            item.op = gbns_pkg::OP_ACK;
            item.ack_flag_data = 1'b0;
         end
         default: begin
            item.op = gbns_pkg::OP_ACK;
            item.ack_num = SEQ_LIMIT;
         end
      endcase
      send_item(item);
   endtask

   function automatic logic [LEN_W-1:0] rand_seg_len();
      if ($urandom_range(0, 7) == 0)
         return LEN_W'($urandom_range(SEGMENT_BYTES + 1, LEN_MAX));
      return LEN_W'($urandom_range(0, SEGMENT_BYTES));
   endfunction

   task automatic wait_for_notices();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (window_notices_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      // Rejected acks of every sort; ack 0 would otherwise fill the empty window.
      send_ack(16'd0, 1'b1, 1'b0);
      send_ack(16'd0, 1'b0, 1'b1);
      send_ack(SEQ_LIMIT, 1'b1, 1'b1);
      send_expiry();
      send_offer('0);
      send_offer(LEN_W'(LEN_MAX));
      send_offer(LEN_W'(SEGMENT_BYTES + 1));
      send_offer(LEN_W'(SEGMENT_BYTES));
      // No ack seen yet, so the base goes back to zero.
      send_expiry();
      send_ack(16'd1, 1'b1, 1'b1);
      send_ack(16'd0, 1'b1, 1'b1);
      send_expiry();
      send_ack(full_ack_num, 1'b1, 1'b1);
      send_expiry();
      send_expiry();
      send_offer(rand_seg_len());
      // The base now falls back behind the advanced window, past next_seq.
      send_expiry();
      send_noise();
      wait_for_notices();
   endtask

   task automatic test_random_rounds();
      int unsigned work_items;
      int unsigned n_offers;
      int unsigned round;
      int unsigned pick;
      int unsigned lo;
      int unsigned hi;
      work_items = 0;
      round = 0;
      while (work_items < 400) begin
         n_offers = $urandom_range(1, 24);
         repeat (n_offers) begin
            send_offer(rand_seg_len());
            if ($urandom_range(0, 9) == 0)
               send_noise();
         end
         work_items += n_offers;
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            // Acknowledge the whole window, then move it once or twice.
            send_ack(full_ack_num, 1'b1, 1'b1);
            n_offers = $urandom_range(1, 2);
            repeat (n_offers) send_expiry();
            work_items += 1 + n_offers;
         end else if (pick < 8) begin
            lo = (ack_seen && $urandom_range(0, 3) != 0) ? 32'(top_ack) : 0;
            hi = (next_seq == 0) ? 0 : next_seq - 1;
            if (hi < lo)
               hi = lo;
            send_ack(SEQ_W'($urandom_range(lo, hi)), 1'b1, 1'b1);
            if ($urandom_range(0, 3) == 0)
               send_noise();
            send_expiry();
            work_items += 2;
         end else begin
            send_expiry();
            work_items++;
         end
         round++;
         if (round % 6 == 5)
            wait_for_notices();
      end
      wait_for_notices();
   endtask

   task automatic test_top_of_sequence();
      // The closing part of the run goes without idle cycles on either side.
      quiet = 1'b1;
      // An offer clears the all-acked mark; a refused one needs the window moved first.
      while (all_acked) begin
         send_offer(rand_seg_len());
         if (all_acked)
            send_expiry();
      end
      send_ack(HIGH_BASE - 16'd1, 1'b1, 1'b1);
      send_expiry();
      send_offer(rand_seg_len());
      send_ack(HIGH_BASE + 16'(WINDOW - 1), 1'b1, 1'b1);
      // Three advances: the second reaches the top and the third stays there.
      send_expiry();
      send_expiry();
      send_expiry();
      // The full-window ack number saturates from here on.
      send_offer(rand_seg_len());
      wait_for_notices();
   endtask

   always @(posedge clock) begin : notice_checker
      gbns_pkg::rsp_payload_type got;
      gbns_pkg::rsp_payload_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (window_notices_due.size() == 0) begin
            report_mismatch($sformatf("beat with nothing expected: kind %0d seq %0d",
                                      got.kind, got.seq));
         end else begin
            want = window_notices_due.pop_front();
            if (got.kind !== want.kind)
               report_mismatch($sformatf("kind %0d, expected %0d (seq %0d)",
                                         got.kind, want.kind, want.seq));
            if (got.seq !== want.seq)
               report_mismatch($sformatf("seq %0d, expected %0d", got.seq, want.seq));
            if (got.length !== want.length)
               report_mismatch($sformatf("length %0d, expected %0d (seq %0d)",
                                         got.length, want.length, want.seq));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b (seq %0d)",
                                         got.last, want.last, want.seq));
         end
      end
   end

   initial begin : receiver_pacing
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_rounds();
      test_top_of_sequence();
      // Room for a full retransmit burst that nothing predicted.
      repeat (WINDOW + 8) @(posedge clock);
      if (mismatches == 0 && window_notices_due.size() == 0) begin
         $display("go_back_n_send_window_test OK");
      end else begin
         $display("go_back_n_send_window_test NOT OK");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("go_back_n_send_window_test NOT OK");
      $finish;
   end

endmodule

/* sim.f */
rtl/gbns_pkg.sv
rtl/gbns_if.sv
rtl/go_back_n_send_window.sv
rtl/gbns_checker.sv
dv/go_back_n_send_window_test.sv
